@@ sv/ipv6_syn_cookie_engine_defines.svh @@
// Assertion macros for the IPv6 SYN cookie engine.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef IPV6_SYN_COOKIE_ENGINE_DEFINES_SVH
`define IPV6_SYN_COOKIE_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define SCE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sce assertion failed");
// Checked property that must also hold during reset.
`define SCE_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sce assertion failed");
`else
`define SCE_ASSERT(lbl, clk, rstn, prop)
`define SCE_ASSERT_NORST(lbl, clk, prop)
`endif

`endif

@@ sv/sce_pkg.sv @@
// Shared constants, types and hash step functions of the IPv6 SYN cookie engine.
// No dependencies.
package sce_pkg;

  localparam int unsigned BucketShiftDef = 5;
  localparam int unsigned NumAddrBytes   = 16;
  localparam int unsigned AddrW          = 8 * NumAddrBytes;

  localparam logic [31:0] FoldMul = 32'h9E37_79B1;
  localparam logic [31:0] MixM1   = 32'h9E37_79B1;
  localparam logic [31:0] MixM2   = 32'h85EB_CA77;
  localparam logic [31:0] MixM3   = 32'hC2B2_AE3D;
  localparam logic [31:0] MixM4   = 32'h27D4_EB2F;
  localparam logic [31:0] SrcSeed = 32'h811C_9DC5;
  localparam logic [31:0] DstSeed = 32'h0100_0193;

  localparam logic CmdGenerate = 1'b0;
  localparam logic CmdValidate = 1'b1;

  // Per-item data that rides alongside the hash lanes.
  typedef struct packed {
    logic        cmd;
    logic [31:0] ports;
    logic [31:0] ack_m1;
  } side_t;

  typedef struct packed {
    logic [31:0] cookie;
    logic        accepted;
  } rsp_t;

  function automatic logic [31:0] fold_step(logic [31:0] h, logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * FoldMul;
  endfunction

  function automatic logic [31:0] mix_step(logic [31:0] h, logic [31:0] v,
                                           logic [31:0] m);
    logic [31:0] x;
    x = h ^ v;
    return x * m;
  endfunction

  function automatic logic [31:0] finish(logic [31:0] h);
    return h ^ (h >> 15);
  endfunction

endpackage

@@ sv/sce_if.sv @@
// Valid/ready channel interfaces of the IPv6 SYN cookie engine.
// Depends on nothing; payload fields follow the block's item layout.
interface sce_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] src_addr_hi;
  logic [63:0] src_addr_lo;
  logic [15:0] src_port_num;
  logic [63:0] dst_addr_hi;
  logic [63:0] dst_addr_lo;
  logic [15:0] dst_port_num;
  logic [31:0] ack_number;
  logic [31:0] tick_now;

  modport source (
    output valid, cmd, src_addr_hi, src_addr_lo, src_port_num,
           dst_addr_hi, dst_addr_lo, dst_port_num, ack_number, tick_now,
    input  ready
  );
  modport sink (
    input  valid, cmd, src_addr_hi, src_addr_lo, src_port_num,
           dst_addr_hi, dst_addr_lo, dst_port_num, ack_number, tick_now,
    output ready
  );
endinterface

interface sce_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] cookie;
  logic        accepted;

  modport source (output valid, cookie, accepted, input ready);
  modport sink (input valid, cookie, accepted, output ready);
endinterface

interface sce_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] secret_key;

  modport source (output valid, secret_key, input ready);
  modport sink (input valid, secret_key, output ready);
endinterface

@@ sv/sce_fold.sv @@
// Address fold pipeline: one byte of each address per stage, 16 stages.
// Depends on sce_pkg.
module sce_fold #(
  parameter int unsigned BUCKET_SHIFT = sce_pkg::BucketShiftDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  logic [sce_pkg::AddrW-1:0]   src_addr_i,
  input  logic [sce_pkg::AddrW-1:0]   dst_addr_i,
  input  sce_pkg::side_t              side_i,
  input  logic [31-BUCKET_SHIFT:0]    bucket_i,
  output logic                        valid_o,
  output logic [31:0]                 src_hash_o,
  output logic [31:0]                 dst_hash_o,
  output sce_pkg::side_t              side_o,
  output logic [31-BUCKET_SHIFT:0]    bucket_o
);

  localparam int unsigned NStg    = sce_pkg::NumAddrBytes;
  localparam int unsigned BucketW = 32 - BUCKET_SHIFT;

  logic [NStg-1:0]                valid_q;
  logic [sce_pkg::AddrW-1:0]      src_addr_q [NStg];
  logic [sce_pkg::AddrW-1:0]      dst_addr_q [NStg];
  logic [31:0]                    src_h_q    [NStg];
  logic [31:0]                    dst_h_q    [NStg];
  sce_pkg::side_t                 side_q     [NStg];
  logic [BucketW-1:0]             bucket_q   [NStg];

  for (genvar k = 0; k < NStg; k++) begin : g_stage
    logic                       v_in;
    logic [sce_pkg::AddrW-1:0]  sa_in;
    logic [sce_pkg::AddrW-1:0]  da_in;
    logic [31:0]                sh_in;
    logic [31:0]                dh_in;
    sce_pkg::side_t             side_in;
    logic [BucketW-1:0]         b_in;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign sa_in   = src_addr_i;
      assign da_in   = dst_addr_i;
      assign sh_in   = sce_pkg::SrcSeed;
      assign dh_in   = sce_pkg::DstSeed;
      assign side_in = side_i;
      assign b_in    = bucket_i;
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign sa_in   = src_addr_q[k-1];
      assign da_in   = dst_addr_q[k-1];
      assign sh_in   = src_h_q[k-1];
      assign dh_in   = dst_h_q[k-1];
      assign side_in = side_q[k-1];
      assign b_in    = bucket_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (adv_i) begin
        valid_q[k] <= v_in;
      end
    end

    // byte k sits at bits 127-8k downward (byte 0 in the top bits)
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        src_addr_q[k] <= sa_in;
        dst_addr_q[k] <= da_in;
        src_h_q[k]    <= sce_pkg::fold_step(sh_in, sa_in[sce_pkg::AddrW-1-8*k -: 8]);
        dst_h_q[k]    <= sce_pkg::fold_step(dh_in, da_in[sce_pkg::AddrW-1-8*k -: 8]);
        side_q[k]     <= side_in;
        bucket_q[k]   <= b_in;
      end
    end
  end

  assign valid_o    = valid_q[NStg-1];
  assign src_hash_o = src_h_q[NStg-1];
  assign dst_hash_o = dst_h_q[NStg-1];
  assign side_o     = side_q[NStg-1];
  assign bucket_o   = bucket_q[NStg-1];

endmodule

@@ sv/sce_mix.sv @@
// Mix pipeline: secret, folds, ports and bucket mixed over four multiply stages,
// then finish and compare in a fifth. Depends on sce_pkg.
module sce_mix #(
  parameter int unsigned BUCKET_SHIFT = sce_pkg::BucketShiftDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic [31:0]               secret_key_i,
  input  logic                      valid_i,
  input  logic [31:0]               src_hash_i,
  input  logic [31:0]               dst_hash_i,
  input  sce_pkg::side_t            side_i,
  input  logic [31-BUCKET_SHIFT:0]  bucket_i,
  output logic                      valid_o,
  output sce_pkg::rsp_t             rsp_o
);

  localparam int unsigned BucketW = 32 - BUCKET_SHIFT;

  logic [4:0]          valid_q;
  logic [31:0]         h1_q, h2_q, h3_q, hc_q, hp_q;
  logic [31:0]         dst_hash1_q;
  sce_pkg::side_t      side1_q, side2_q, side3_q, side4_q;
  logic [BucketW-1:0]  bucket1_q, bucket2_q, bucket3_q;
  logic                has_prev4_q;
  sce_pkg::rsp_t       rsp_q;
  logic [31:0]         cookie_now, cookie_prev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[3:0], valid_i};
    end
  end

  always_comb begin
    cookie_now  = sce_pkg::finish(hc_q);
    cookie_prev = sce_pkg::finish(hp_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      h1_q        <= sce_pkg::mix_step(secret_key_i, src_hash_i, sce_pkg::MixM1);
      dst_hash1_q <= dst_hash_i;
      side1_q     <= side_i;
      bucket1_q   <= bucket_i;

      h2_q        <= sce_pkg::mix_step(h1_q, dst_hash1_q, sce_pkg::MixM2);
      side2_q     <= side1_q;
      bucket2_q   <= bucket1_q;

      h3_q        <= sce_pkg::mix_step(h2_q, side2_q.ports, sce_pkg::MixM3);
      side3_q     <= side2_q;
      bucket3_q   <= bucket2_q;

      // current and previous bucket lanes split here
      hc_q        <= sce_pkg::mix_step(h3_q, 32'(bucket3_q), sce_pkg::MixM4);
      hp_q        <= sce_pkg::mix_step(h3_q, 32'(bucket3_q - BucketW'(1)), sce_pkg::MixM4);
      has_prev4_q <= |bucket3_q;
      side4_q     <= side3_q;

      rsp_q.cookie   <= cookie_now;
      rsp_q.accepted <= (side4_q.cmd == sce_pkg::CmdValidate) &&
                        ((side4_q.ack_m1 == cookie_now) ||
                         (has_prev4_q && (side4_q.ack_m1 == cookie_prev)));
    end
  end

  assign valid_o = valid_q[4];
  assign rsp_o   = rsp_q;

endmodule

@@ sv/sce_out_skid.sv @@
// Two-entry output buffer that decouples the pipeline stall from the receiver.
// Depends on sce_pkg, sce_rsp_if and the assertion macro header.
`include "ipv6_syn_cookie_engine_defines.svh"

module sce_out_skid (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  sce_pkg::rsp_t   in_data_i,
  output logic            in_ready_o,
  sce_rsp_if.source       rsp_o
);

  logic           out_valid_q;
  logic           spare_valid_q;
  sce_pkg::rsp_t  out_data_q;
  sce_pkg::rsp_t  spare_data_q;
  logic           take_in;
  logic           take_out;

  assign in_ready_o = !spare_valid_q;
  assign take_in    = in_valid_i && !spare_valid_q;
  assign take_out   = out_valid_q && rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      spare_valid_q <= 1'b0;
    end else if (!out_valid_q || take_out) begin
      if (spare_valid_q) begin
        out_valid_q   <= 1'b1;
        spare_valid_q <= 1'b0;
      end else begin
        out_valid_q   <= take_in;
      end
    end else if (take_in) begin
      spare_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take_out) begin
      out_data_q <= spare_valid_q ? spare_data_q : in_data_i;
    end
    if (take_in && out_valid_q && !take_out) begin
      spare_data_q <= in_data_i;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.cookie   = out_data_q.cookie;
  assign rsp_o.accepted = out_data_q.accepted;

  `SCE_ASSERT_NORST(a_spare_implies_out, clk_i, spare_valid_q |-> out_valid_q)
  `SCE_ASSERT(a_spare_fill_on_stall, clk_i, rst_ni,
              $rose(spare_valid_q) |-> $past(out_valid_q && !rsp_o.ready))
  `SCE_ASSERT(a_spare_drains, clk_i, rst_ni,
              (out_valid_q && rsp_o.ready && spare_valid_q) |=> (out_valid_q && !spare_valid_q))

endmodule

@@ sv/ipv6_syn_cookie_engine.sv @@
// TCP SYN cookie generate/check engine for IPv6 flows.
// Channels: req_i carries one request per transfer (command, both addresses as
// hi/lo halves, both ports, ack number, tick count); rsp_o returns exactly one
// result per request (cookie of the current time bucket, accepted flag), in order.
// cfg_i writes the 32-bit secret; it is always ready. The user must write it only while
// no request is in flight; the block itself does not enforce this.
// Throughput: one request per cycle while the pipeline is not held (see below). A request
// accepted at a clock edge is loaded into the first of 22 register stages: 16 fold
// stages (one address byte each, both addresses side by side), 5 mix stages (four
// multiply stages, then finish and compare) and the output register, from which its
// result shows on rsp_o.
// Reset clears all valid bits and the secret to zero; nothing else needs time.
// When rsp_o stalls, a two-entry output buffer takes the item in flight; once it
// is full and the last mix stage holds an item, the pipeline holds in place and
// req_i.ready drops; it depends only on registered state, not on rsp_o.ready.
// Depends on sce_pkg, sce_if, sce_fold, sce_mix and sce_out_skid.
module ipv6_syn_cookie_engine #(
  parameter int unsigned BUCKET_SHIFT = sce_pkg::BucketShiftDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sce_cfg_if.sink    cfg_i,
  sce_req_if.sink    req_i,
  sce_rsp_if.source  rsp_o
);

  localparam int unsigned BucketW = 32 - BUCKET_SHIFT;

  logic [31:0]         secret_q;
  logic                adv;
  logic                skid_ready;
  sce_pkg::side_t      side_in;
  logic [BucketW-1:0]  bucket_in;

  logic                fold_valid;
  logic [31:0]         src_hash, dst_hash;
  sce_pkg::side_t      fold_side;
  logic [BucketW-1:0]  fold_bucket;

  logic                mix_valid;
  sce_pkg::rsp_t       mix_rsp;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      secret_q <= '0;
    end else if (cfg_i.valid) begin
      secret_q <= cfg_i.secret_key;
    end
  end

  // whole pipe moves together unless the last stage holds an item with nowhere to go
  assign adv         = !mix_valid || skid_ready;
  assign req_i.ready = adv;

  assign side_in.cmd    = req_i.cmd;
  assign side_in.ports  = {req_i.src_port_num, req_i.dst_port_num};
  assign side_in.ack_m1 = req_i.ack_number - 32'd1;
  assign bucket_in      = BucketW'(req_i.tick_now >> BUCKET_SHIFT);

  sce_fold #(
    .BUCKET_SHIFT (BUCKET_SHIFT)
  ) u_fold (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (req_i.valid),
    .src_addr_i ({req_i.src_addr_hi, req_i.src_addr_lo}),
    .dst_addr_i ({req_i.dst_addr_hi, req_i.dst_addr_lo}),
    .side_i     (side_in),
    .bucket_i   (bucket_in),
    .valid_o    (fold_valid),
    .src_hash_o (src_hash),
    .dst_hash_o (dst_hash),
    .side_o     (fold_side),
    .bucket_o   (fold_bucket)
  );

  sce_mix #(
    .BUCKET_SHIFT (BUCKET_SHIFT)
  ) u_mix (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .secret_key_i (secret_q),
    .valid_i      (fold_valid),
    .src_hash_i   (src_hash),
    .dst_hash_i   (dst_hash),
    .side_i       (fold_side),
    .bucket_i     (fold_bucket),
    .valid_o      (mix_valid),
    .rsp_o        (mix_rsp)
  );

  sce_out_skid u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (mix_valid),
    .in_data_i  (mix_rsp),
    .in_ready_o (skid_ready),
    .rsp_o      (rsp_o)
  );

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for ipv6_syn_cookie_engine: directed table, then random flows.
// Depends on sce_pkg, sce_if and the engine RTL; predicts each cookie and accept flag itself.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CmdGenerate = sce_pkg::CmdGenerate;
  localparam logic CmdValidate = sce_pkg::CmdValidate;

  localparam int unsigned BktShift      = 5;
  localparam int          WatchdogLimit = 3000;
  localparam int          NumRows       = 20;
  localparam int          PhaseItems    = 420;

  localparam logic [31:0] HashMul  = 32'h9E37_79B1;
  localparam logic [31:0] KeyMul1  = 32'h9E37_79B1;
  localparam logic [31:0] KeyMul2  = 32'h85EB_CA77;
  localparam logic [31:0] KeyMul3  = 32'hC2B2_AE3D;
  localparam logic [31:0] KeyMul4  = 32'h27D4_EB2F;
  localparam logic [31:0] SrcBasis = 32'h811C_9DC5;
  localparam logic [31:0] DstBasis = 32'h0100_0193;

  localparam logic [63:0] Z64 = 64'h0;
  localparam logic [63:0] F64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] A64 = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [63:0] S64 = 64'h5555_5555_5555_5555;
  localparam logic [63:0] P64 = 64'h0123_4567_89AB_CDEF;
  localparam logic [63:0] Q64 = 64'hFEDC_BA98_7654_3210;
  localparam logic [63:0] D64 = 64'h2001_0DB8_0000_0000;

  // How the ack of a validate is formed: taken as is, or from the cookie of a bucket.
  typedef enum logic [1:0] {
    AckAsGiven,
    AckNowBucket,
    AckPrevBucket,
    AckTwoBack
  } ack_mode_e;

  typedef struct packed {
    logic        cmd;
    logic [63:0] sa_hi, sa_lo;
    logic [15:0] sport;
    logic [63:0] da_hi, da_lo;
    logic [15:0] dport;
    logic [31:0] ack;
    logic [31:0] tick;
  } syn_req_t;

  typedef struct packed {
    logic [31:0] cookie;
    logic        accepted;
  } cookie_rsp_t;

  // typed = 1: accepted flag is the one given in the row, not the predicted one
  typedef struct packed {
    syn_req_t  req;
    ack_mode_e mode;
    logic      typed;
    logic      acc;
  } stim_row_t;

  localparam stim_row_t StimTable [NumRows] = '{
    '{'{CmdGenerate, Z64, Z64, 16'h0000, Z64, Z64, 16'h0000, 32'h0, 32'h0},
      AckAsGiven, 1'b1, 1'b0},
    '{'{CmdGenerate, F64, F64, 16'hFFFF, F64, F64, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      AckAsGiven, 1'b1, 1'b0},
    '{'{CmdGenerate, A64, S64, 16'hAAAA, S64, A64, 16'h5555, 32'h0, 32'h0000_001F},
      AckAsGiven, 1'b1, 1'b0},
    '{'{CmdGenerate, P64, Q64, 16'h01BB, D64, 64'h1, 16'hC350, 32'h1234_5678, 32'h20},
      AckAsGiven, 1'b1, 1'b0},
    '{'{CmdGenerate, F64, Z64, 16'h0050, Z64, F64, 16'hFFFF, 32'h8000_0000, 32'hFFFF_FFE0},
      AckAsGiven, 1'b1, 1'b0},
    '{'{CmdValidate, Z64, Z64, 16'h0000, Z64, Z64, 16'h0000, 32'h0, 32'h0},
      AckNowBucket, 1'b1, 1'b1},
    '{'{CmdValidate, F64, F64, 16'hFFFF, F64, F64, 16'hFFFF, 32'h0, 32'hFFFF_FFFF},
      AckNowBucket, 1'b1, 1'b1},
    '{'{CmdValidate, A64, S64, 16'h1234, S64, A64, 16'hABCD, 32'h0, 32'h20},
      AckPrevBucket, 1'b1, 1'b1},
    '{'{CmdValidate, F64, F64, 16'hFFFF, F64, F64, 16'hFFFF, 32'h0, 32'hFFFF_FFFF},
      AckPrevBucket, 1'b1, 1'b1},
    // bucket zero: no previous bucket to fall back on
    '{'{CmdValidate, Z64, Z64, 16'h0000, Z64, Z64, 16'h0000, 32'h0, 32'h0000_001F},
      AckPrevBucket, 1'b0, 1'b0},
    '{'{CmdValidate, P64, Q64, 16'h01BB, D64, 64'h1, 16'hC350, 32'h0, 32'h40},
      AckTwoBack, 1'b0, 1'b0},
    // ack of zero wraps to all ones
    '{'{CmdValidate, Z64, Z64, 16'h0000, Z64, Z64, 16'h0000, 32'h0, 32'h0},
      AckAsGiven, 1'b0, 1'b0},
    '{'{CmdValidate, Z64, Z64, 16'h0000, Z64, Z64, 16'h0000, 32'h1, 32'h0},
      AckAsGiven, 1'b0, 1'b0},
    '{'{CmdValidate, F64, F64, 16'hFFFF, F64, F64, 16'hFFFF, 32'hFFFF_FFFF, 32'h1F},
      AckAsGiven, 1'b0, 1'b0},
    '{'{CmdValidate, F64, F64, 16'h0000, F64, F64, 16'h0000, 32'h0, 32'h3F},
      AckNowBucket, 1'b1, 1'b1},
    '{'{CmdValidate, Z64, Z64, 16'hFFFF, Z64, Z64, 16'h0000, 32'h0, 32'h40},
      AckNowBucket, 1'b1, 1'b1},
    '{'{CmdValidate, A64, S64, 16'h5555, S64, A64, 16'hAAAA, 32'h8000_0000, 32'h8000_0000},
      AckAsGiven, 1'b0, 1'b0},
    '{'{CmdValidate, S64, A64, 16'h5555, A64, S64, 16'hAAAA, 32'h0, 32'h8000_0000},
      AckPrevBucket, 1'b1, 1'b1},
    '{'{CmdGenerate, D64, 64'h1, 16'h0016, P64, Q64, 16'h8000, 32'h0, 32'h7FFF_FFFF},
      AckAsGiven, 1'b1, 1'b0},
    '{'{CmdValidate, F64, F64, 16'hFFFF, F64, F64, 16'hFFFF, 32'h0, 32'hFFFF_FFFF},
      AckTwoBack, 1'b0, 1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  sce_cfg_if cfg ();
  sce_req_if req ();
  sce_rsp_if rsp ();

  ipv6_syn_cookie_engine #(
    .BUCKET_SHIFT(BktShift)
  ) dut (
    .clk_i,
    .rst_ni,
    .cfg_i(cfg),
    .req_i(req),
    .rsp_o(rsp)
  );

  always #5 clk_i = ~clk_i;

  logic [31:0]  secret_now;
  cookie_rsp_t  expected_cookies [$];
  cookie_rsp_t  rsp_want;
  int           n_errors    = 0;
  int           n_results   = 0;
  int           idle_cycles = 0;
  int           gap_pct     = 0;
  int           stall_pct   = 0;

  function automatic logic [31:0] addr_hash(logic [31:0] basis, logic [63:0] hi,
                                            logic [63:0] lo);
    logic [127:0] addr;
    logic [31:0]  h;
    addr = {hi, lo};
    h = basis;
    for (int i = 15; i >= 0; i--) h = (h ^ {24'd0, addr[i*8 +: 8]}) * HashMul;
    return h;
  endfunction

  function automatic logic [31:0] flow_cookie(syn_req_t r, logic [31:0] bucket);
    logic [31:0] h;
    h = (secret_now ^ addr_hash(SrcBasis, r.sa_hi, r.sa_lo)) * KeyMul1;
    h = (h ^ addr_hash(DstBasis, r.da_hi, r.da_lo)) * KeyMul2;
    h = (h ^ {r.sport, r.dport}) * KeyMul3;
    h = (h ^ bucket) * KeyMul4;
    return h ^ (h >> 15);
  endfunction

  function automatic cookie_rsp_t predict_cookie(syn_req_t r);
    cookie_rsp_t res;
    logic [31:0] bkt;
    logic [31:0] ack_m1;
    bkt = r.tick >> BktShift;
    ack_m1 = r.ack - 32'd1;
    res.cookie = flow_cookie(r, bkt);
    res.accepted = 1'b0;
    if (r.cmd == CmdValidate) begin
      if (ack_m1 == res.cookie) res.accepted = 1'b1;
      else if (bkt != 32'd0 && ack_m1 == flow_cookie(r, bkt - 32'd1)) res.accepted = 1'b1;
    end
    return res;
  endfunction

  function automatic syn_req_t with_ack(syn_req_t r, ack_mode_e mode);
    logic [31:0] bkt;
    bkt = r.tick >> BktShift;
    case (mode)
      AckNowBucket:  r.ack = flow_cookie(r, bkt) + 32'd1;
      AckPrevBucket: r.ack = flow_cookie(r, bkt - 32'd1) + 32'd1;
      AckTwoBack:    r.ack = flow_cookie(r, bkt - 32'd2) + 32'd1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand_half();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) return Z64;
    if (pick == 1) return F64;
    return {$urandom, $urandom};
  endfunction

  // Mostly validates, most from a live cookie, the rest with a stale or stray ack; also generates.
  function automatic syn_req_t rand_flow_req();
    syn_req_t  r;
    ack_mode_e mode;
    int        pick;
    r.sa_hi = rand_half();
    r.sa_lo = rand_half();
    r.da_hi = rand_half();
    r.da_lo = rand_half();
    r.sport = 16'($urandom);
    r.dport = 16'($urandom);
    r.ack   = $urandom;
    pick = $urandom_range(9);
    if (pick == 0) r.tick = $urandom_range(95);
    else if (pick == 1) r.tick = 32'hFFFF_FFFF - $urandom_range(95);
    else r.tick = $urandom;
    pick = $urandom_range(99);
    r.cmd = CmdValidate;
    if (pick < 30) begin
      r.cmd = CmdGenerate;
      mode = AckAsGiven;
    end else if (pick < 55) mode = AckNowBucket;
    else if (pick < 75) mode = AckPrevBucket;
    else if (pick < 85) mode = AckTwoBack;
    else begin
      mode = AckAsGiven;
      if (pick > 96) r.ack = 32'h0;
    end
    return with_ack(r, mode);
  endfunction

  task automatic flag_error(input string what);
    $display("%0t  mismatch: %s", $time, what);
    n_errors++;
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input syn_req_t r, input logic typed, input logic typed_acc);
    cookie_rsp_t want;
    while ($urandom_range(99) < gap_pct) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.cmd          <= r.cmd;
    req.src_addr_hi  <= r.sa_hi;
    req.src_addr_lo  <= r.sa_lo;
    req.src_port_num <= r.sport;
    req.dst_addr_hi  <= r.da_hi;
    req.dst_addr_lo  <= r.da_lo;
    req.dst_port_num <= r.dport;
    req.ack_number   <= r.ack;
    req.tick_now     <= r.tick;
    req.valid        <= 1'b1;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    want = predict_cookie(r);
    if (typed) want.accepted = typed_acc;
    expected_cookies.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_cookies.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_secret(input logic [31:0] key);
    cfg.secret_key <= key;
    cfg.valid      <= 1'b1;
    do @(posedge clk_i); while (cfg.ready !== 1'b1);
    secret_now = key;
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  task automatic run_phase(input int n, input int gap, input int stall, input bit hold_mid);
    gap_pct   = gap;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      // hold the sender until the pipeline is empty once
      if (hold_mid && i == n / 2) begin
        req.valid <= 1'b0;
        wait_drained();
      end
      send_item(rand_flow_req(), 1'b0, 1'b0);
    end
    req.valid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    rsp.ready = 1'b1;
    forever begin
      @(negedge clk_i);
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      n_results++;
      if (expected_cookies.size() == 0) begin
        flag_error($sformatf("result %0d (cookie %h, accepted %b) with none pending",
                             n_results, rsp.cookie, rsp.accepted));
      end else begin
        rsp_want = expected_cookies.pop_front();
        if (rsp.cookie !== rsp_want.cookie)
          flag_error($sformatf("result %0d cookie %h, want %h",
                               n_results, rsp.cookie, rsp_want.cookie));
        if (rsp.accepted !== rsp_want.accepted)
          flag_error($sformatf("result %0d accepted %b, want %b",
                               n_results, rsp.accepted, rsp_want.accepted));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req.valid === 1'b1 && req.ready === 1'b1) || (rsp.valid === 1'b1 && rsp.ready === 1'b1)
        || (cfg.valid === 1'b1 && cfg.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               idle_cycles, expected_cookies.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    secret_now       = 32'h0;
    cfg.valid        = 1'b0;
    cfg.secret_key   = 32'h0;
    req.valid        = 1'b0;
    req.cmd          = CmdGenerate;
    req.src_addr_hi  = '0;
    req.src_addr_lo  = '0;
    req.src_port_num = '0;
    req.dst_addr_hi  = '0;
    req.dst_addr_lo  = '0;
    req.dst_port_num = '0;
    req.ack_number   = '0;
    req.tick_now     = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_secret(32'h0);
    for (int k = 0; k < NumRows; k++) begin
      send_item(with_ack(StimTable[k].req, StimTable[k].mode),
                StimTable[k].typed, StimTable[k].acc);
    end
    req.valid <= 1'b0;
    wait_drained();

    write_secret(32'hFFFF_FFFF);
    run_phase(PhaseItems, 0, 0, 1'b1);
    write_secret($urandom);
    run_phase(PhaseItems, 65, 0, 1'b1);
    write_secret(32'h8000_0001);
    run_phase(PhaseItems, 0, 65, 1'b0);
    write_secret($urandom);
    run_phase(PhaseItems, 35, 35, 1'b0);

    repeat (40) @(posedge clk_i);
    if (expected_cookies.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_cookies.size()));
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
